// File: src/falling_sand_grid_step_defines.svh
// ----------------------------------------------------------------------------
// falling_sand_grid_step_defines.svh
// Assertion macros shared by the falling-sand grid block. They expand to
// concurrent assertions in simulation and to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef FALLING_SAND_GRID_STEP_DEFINES_SVH
`define FALLING_SAND_GRID_STEP_DEFINES_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define FSG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
// expression must never be true outside reset
`define FSG_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);
`else
`define FSG_ASSERT(lbl, prop, msg)
`define FSG_NEVER(lbl, expr, msg)
`endif
`endif

// File: src/fsg_pkg.sv
// ----------------------------------------------------------------------------
// fsg_pkg
// Types and fixed codes shared by the falling-sand grid controller and
// datapath.
// ----------------------------------------------------------------------------
package fsg_pkg;

    // opcodes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_GEN   = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;  // unused, result only

    // cell materials
    localparam logic [1:0] KIND_AIR   = 2'd0;
    localparam logic [1:0] KIND_SAND  = 2'd1;
    localparam logic [1:0] KIND_BLOCK = 2'd2;
    localparam logic [1:0] KIND_RSVD  = 2'd3;  // stored as block

    // move counter
    localparam int          MOVES_W   = 13;
    localparam logic [12:0] MOVES_MAX = 13'h1FFF;

    // LFSR feedback
    localparam logic [15:0] LFSR_MASK = 16'hB400;
    localparam logic [15:0] LFSR_ONE  = 16'h0001;

    // memory address source
    typedef logic [1:0] t_amode;
    localparam t_amode AM_OP   = 2'd0;  // from input item
    localparam t_amode AM_IDX  = 2'd1;  // sweep index
    localparam t_amode AM_SELF = 2'd2;  // a: self, b: below
    localparam t_amode AM_DIAG = 2'd3;  // a: below right, b: below left

    // controller -> datapath
    typedef struct packed {
        logic   accept;
        logic   rd_capture;
        logic   clr_wr;
        logic   idx_clr;
        logic   idx_inc;
        logic   copy;
        logic   gen_dir;
        logic   scan_init;
        logic   hold;
        logic   eval;
        logic   wself;
        logic   step;
        logic   swap;
        logic   out_load;
        t_amode amode;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic idx_last;
        logic self_sand;
        logic moved;
        logic scan_last;
    } t_sts;

endpackage

// File: src/fsg_dp.sv
// ----------------------------------------------------------------------------
// fsg_dp
// Grid memories (ping-pong pair), sweep index, scan coordinates, LFSR,
// move decision and result registers.
// ----------------------------------------------------------------------------
`include "falling_sand_grid_step_defines.svh"

module fsg_dp #(
    parameter int GRID_W = 64,
    parameter int GRID_H = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fsg_pkg::t_cmd     i_cmd,
    output fsg_pkg::t_sts     o_sts,
    input  logic [1:0]        i_op,
    input  logic [5:0]        i_col,
    input  logic [5:0]        i_row,
    input  logic [1:0]        i_cell_kind,
    input  logic [15:0]       i_seed,
    output logic [1:0]        o_read_kind,
    output logic [12:0]       o_moves
);

    localparam int N  = GRID_W * GRID_H;
    localparam int AW = $clog2(N);
    localparam int XW = $clog2(GRID_W);
    localparam int YW = $clog2(GRID_H);

    function automatic logic [AW-1:0] cell_addr(input int x, input int y);
        return AW'(y * GRID_W + x);
    endfunction

    logic [1:0]    r_mem0 [N];
    logic [1:0]    r_mem1 [N];
    logic [1:0]    r_rd0a, r_rd0b, r_rd1a, r_rd1b;
    logic          r_cur;
    logic [AW-1:0] r_idx;
    logic          r_cp_v;
    logic [AW-1:0] r_cp_addr;
    logic [15:0]   r_lfsr, n_lfsr;
    logic          r_dir;
    logic [XW-1:0] r_x, n_x;
    logic [YW-1:0] r_y, n_y;
    logic          r_fb, r_fc, r_ff;
    logic          n_fb, n_fc, n_ff;
    logic [1:0]    r_below;
    logic          r_op_in;
    logic [1:0]    r_res_kind;
    logic [12:0]   r_moves;
    logic [1:0]    r_out_kind;
    logic [12:0]   r_out_moves;

    logic [1:0]    rd_a, rd_b;
    logic [AW-1:0] addr_a, addr_b, waddr;
    logic [1:0]    wdata, kind_w;
    logic          wr_cur, wr_oth, we0, we1;
    logic          op_in;
    logic [AW-1:0] op_addr, self_addr, below_addr, right_addr, left_addr, tgt_addr;
    logic [XW-1:0] x_first, x_last;
    logic          below_ok, x_hi, x_lo, fill_r, fill_l;
    logic          free_d, free_r, free_l, go_r, go_l, move, draw;
    int            xi, yi, tx;

    assign rd_a = r_cur ? r_rd1a : r_rd0a;
    assign rd_b = r_cur ? r_rd1b : r_rd0b;

    assign xi = int'(r_x);
    assign yi = int'(r_y);

    assign op_in   = (int'(i_col) < GRID_W) && (int'(i_row) < GRID_H);
    assign op_addr = cell_addr(int'(i_col), int'(i_row));
    assign kind_w  = (i_cell_kind == fsg_pkg::KIND_RSVD) ? fsg_pkg::KIND_BLOCK : i_cell_kind;

    assign self_addr  = cell_addr(xi, yi);
    assign below_addr = cell_addr(xi, yi + 1);
    assign right_addr = cell_addr(xi + 1, yi + 1);
    assign left_addr  = cell_addr(xi - 1, yi + 1);

    assign x_first = r_dir ? '0 : XW'(GRID_W - 1);
    assign x_last  = r_dir ? XW'(GRID_W - 1) : '0;

    // neighbor checks; fill bits track row-below cells claimed this row
    assign below_ok = yi < GRID_H - 1;
    assign x_hi     = xi < GRID_W - 1;
    assign x_lo     = r_x != '0;
    assign fill_r   = r_dir ? r_ff : r_fb;
    assign fill_l   = r_dir ? r_fb : r_ff;
    assign free_d   = below_ok && (r_below == fsg_pkg::KIND_AIR) && !r_fc;
    assign free_r   = below_ok && x_hi && (rd_a == fsg_pkg::KIND_AIR) && !fill_r;
    assign free_l   = below_ok && x_lo && (rd_b == fsg_pkg::KIND_AIR) && !fill_l;
    assign draw     = !free_d && free_r && free_l;
    assign go_l     = !free_d && (draw ? r_lfsr[0] : (!free_r && free_l));
    assign go_r     = !free_d && free_r && !(draw && r_lfsr[0]);
    assign move     = free_d || go_r || go_l;
    assign tx       = go_r ? xi + 1 : (go_l ? xi - 1 : xi);
    assign tgt_addr = cell_addr(tx, yi + 1);

    always_comb begin
        o_sts           = '0;
        o_sts.idx_last  = r_idx == AW'(N - 1);
        o_sts.self_sand = rd_a == fsg_pkg::KIND_SAND;
        o_sts.moved     = move;
        o_sts.scan_last = (r_y == '0) && (r_x == x_last);
    end

    always_comb begin
        case (i_cmd.amode)
            fsg_pkg::AM_OP: begin
                addr_a = op_addr;
                addr_b = op_addr;
            end
            fsg_pkg::AM_SELF: begin
                addr_a = self_addr;
                addr_b = below_addr;
            end
            fsg_pkg::AM_DIAG: begin
                addr_a = right_addr;
                addr_b = left_addr;
            end
            default: begin
                addr_a = r_idx;
                addr_b = r_idx;
            end
        endcase
    end

    // one write source per cycle
    assign wr_cur = i_cmd.clr_wr || (i_cmd.accept && i_op == fsg_pkg::OP_WRITE && op_in);
    assign wr_oth = r_cp_v || (i_cmd.eval && move) || i_cmd.wself;
    assign we0    = r_cur ? wr_oth : wr_cur;
    assign we1    = r_cur ? wr_cur : wr_oth;

    always_comb begin
        if (i_cmd.clr_wr) begin
            waddr = r_idx;
            wdata = fsg_pkg::KIND_AIR;
        end else if (i_cmd.accept) begin
            waddr = op_addr;
            wdata = kind_w;
        end else if (r_cp_v) begin
            waddr = r_cp_addr;
            wdata = rd_a;
        end else if (i_cmd.eval) begin
            waddr = tgt_addr;
            wdata = fsg_pkg::KIND_SAND;
        end else begin
            waddr = self_addr;
            wdata = fsg_pkg::KIND_AIR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we0) begin
            r_mem0[waddr] <= wdata;
        end
        r_rd0a <= r_mem0[addr_a];
        r_rd0b <= r_mem0[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (we1) begin
            r_mem1[waddr] <= wdata;
        end
        r_rd1a <= r_mem1[addr_a];
        r_rd1b <= r_mem1[addr_b];
    end

    // LFSR
    always_comb begin
        n_lfsr = r_lfsr;
        if (i_cmd.accept && i_op == fsg_pkg::OP_GEN) begin
            n_lfsr = (i_seed == '0) ? fsg_pkg::LFSR_ONE : i_seed;
        end else if (i_cmd.gen_dir || (i_cmd.eval && draw)) begin
            n_lfsr = {1'b0, r_lfsr[15:1]} ^ (r_lfsr[0] ? fsg_pkg::LFSR_MASK : '0);
        end
    end

    // scan position and fill window
    always_comb begin
        n_x  = r_x;
        n_y  = r_y;
        n_fb = r_fb;
        n_fc = r_fc;
        n_ff = r_ff;
        if (i_cmd.eval) begin
            if (free_d) begin
                n_fc = 1'b1;
            end
            if (go_r) begin
                if (r_dir) begin
                    n_ff = 1'b1;
                end else begin
                    n_fb = 1'b1;
                end
            end
            if (go_l) begin
                if (r_dir) begin
                    n_fb = 1'b1;
                end else begin
                    n_ff = 1'b1;
                end
            end
        end
        if (i_cmd.scan_init) begin
            n_x  = x_first;
            n_y  = YW'(GRID_H - 1);
            n_fb = 1'b0;
            n_fc = 1'b0;
            n_ff = 1'b0;
        end else if (i_cmd.step) begin
            if (r_x == x_last) begin
                n_x  = x_first;
                n_y  = r_y - 1'b1;
                n_fb = 1'b0;
                n_fc = 1'b0;
                n_ff = 1'b0;
            end else begin
                n_x  = r_dir ? r_x + 1'b1 : r_x - 1'b1;
                n_fb = n_fc;
                n_fc = n_ff;
                n_ff = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= 1'b0;
            r_idx   <= '0;
            r_cp_v  <= 1'b0;
            r_lfsr  <= fsg_pkg::LFSR_ONE;
            r_dir   <= 1'b0;
            r_x     <= '0;
            r_y     <= '0;
            r_fb    <= 1'b0;
            r_fc    <= 1'b0;
            r_ff    <= 1'b0;
            r_moves <= '0;
        end else begin
            if (i_cmd.swap) begin
                r_cur <= !r_cur;
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            r_cp_v <= i_cmd.copy;
            r_lfsr <= n_lfsr;
            if (i_cmd.gen_dir) begin
                r_dir <= r_lfsr[0];
            end
            r_x  <= n_x;
            r_y  <= n_y;
            r_fb <= n_fb;
            r_fc <= n_fc;
            r_ff <= n_ff;
            if (i_cmd.accept) begin
                r_moves <= '0;
            end else if (i_cmd.eval && move && r_moves != fsg_pkg::MOVES_MAX) begin
                r_moves <= r_moves + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_addr <= r_idx;
        if (i_cmd.hold) begin
            r_below <= rd_b;
        end
        if (i_cmd.accept) begin
            r_op_in    <= op_in;
            r_res_kind <= fsg_pkg::KIND_AIR;
        end else if (i_cmd.rd_capture) begin
            r_res_kind <= r_op_in ? rd_a : fsg_pkg::KIND_BLOCK;
        end
        if (i_cmd.out_load) begin
            r_out_kind  <= r_res_kind;
            r_out_moves <= r_moves;
        end
    end

    assign o_read_kind = r_out_kind;
    assign o_moves     = r_out_moves;

    `FSG_NEVER(a_one_wr_src, wr_cur && wr_oth, "both grid memories written from two sources")
    `FSG_ASSERT(a_moves_mono, !i_cmd.accept |=> r_moves >= $past(r_moves), "move count decreased")

endmodule

// File: src/fsg_ctrl.sv
// ----------------------------------------------------------------------------
// fsg_ctrl
// Sequencer: clearing pass, op dispatch, grid copy, cell-by-cell scan and
// result handoff.
// ----------------------------------------------------------------------------
`include "falling_sand_grid_step_defines.svh"

module fsg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_op,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  fsg_pkg::t_sts i_sts,
    output fsg_pkg::t_cmd o_cmd
);

    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_RDW   = 4'd2;
    localparam logic [3:0] ST_GDIR  = 4'd3;
    localparam logic [3:0] ST_COPY  = 4'd4;
    localparam logic [3:0] ST_CFL   = 4'd5;
    localparam logic [3:0] ST_RD1   = 4'd6;
    localparam logic [3:0] ST_RD2   = 4'd7;
    localparam logic [3:0] ST_EVAL  = 4'd8;
    localparam logic [3:0] ST_WSELF = 4'd9;
    localparam logic [3:0] ST_SWAP  = 4'd10;
    localparam logic [3:0] ST_DONE  = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    assign o_in_ready  = r_state == ST_IDLE;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.amode   = fsg_pkg::AM_IDX;
        case (r_state)
            ST_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.idx_last) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_IDLE: begin
                o_cmd.amode = fsg_pkg::AM_OP;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_op)
                        fsg_pkg::OP_READ: n_state = ST_RDW;
                        fsg_pkg::OP_GEN:  n_state = ST_GDIR;
                        default:          n_state = ST_DONE;
                    endcase
                end
            end
            ST_RDW: begin
                o_cmd.rd_capture = 1'b1;
                n_state = ST_DONE;
            end
            ST_GDIR: begin
                o_cmd.gen_dir = 1'b1;
                o_cmd.idx_clr = 1'b1;
                n_state = ST_COPY;
            end
            ST_COPY: begin
                o_cmd.copy = 1'b1;
                if (i_sts.idx_last) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state = ST_CFL;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_CFL: begin
                o_cmd.scan_init = 1'b1;
                n_state = ST_RD1;
            end
            ST_RD1: begin
                o_cmd.amode = fsg_pkg::AM_SELF;
                n_state = ST_RD2;
            end
            ST_RD2: begin
                o_cmd.amode = fsg_pkg::AM_DIAG;
                o_cmd.hold  = 1'b1;
                if (i_sts.self_sand) begin
                    n_state = ST_EVAL;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state = i_sts.scan_last ? ST_SWAP : ST_RD1;
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_sts.moved) begin
                    n_state = ST_WSELF;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state = i_sts.scan_last ? ST_SWAP : ST_RD1;
                end
            end
            ST_WSELF: begin
                o_cmd.wself = 1'b1;
                o_cmd.step  = 1'b1;
                n_state = i_sts.scan_last ? ST_SWAP : ST_RD1;
            end
            ST_SWAP: begin
                o_cmd.swap = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `FSG_ASSERT(a_out_from_done, $rose(r_out_valid) |-> $past(r_state) == ST_DONE, "result without done")
    `FSG_ASSERT(a_move_vacates, (r_state == ST_EVAL && i_sts.moved) |=> r_state == ST_WSELF, "moved grain not vacated")

endmodule

// File: src/falling_sand_grid_step.sv
// ----------------------------------------------------------------------------
// falling_sand_grid_step
// Falling-sand cellular automaton on a GRID_W x GRID_H grid: cell write,
// cell read and one-generation step, one result per item.
// ----------------------------------------------------------------------------
// After reset the block clears the grid to air, one cell per cycle, with
// in_ready low. A write goes from acceptance straight to the result handoff;
// a read first passes through a capture state. A generation first copies
// the current grid into the other buffer, then the scan visits each cell,
// reading self and below and then both diagonals; it evaluates the move of
// each sand cell and, for each grain that moves, clears its old cell. The
// grids are a ping-pong pair of single-write, dual-read memories; the buffer
// roles swap at the end of a generation. Items are taken one at a time; a
// new item is accepted while the previous result still sits in the output
// register.
// ----------------------------------------------------------------------------
module falling_sand_grid_step #(
    parameter int GRID_W = 64,
    parameter int GRID_H = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [5:0]  i_col,
    input  logic [5:0]  i_row,
    input  logic [1:0]  i_cell_kind,
    input  logic [15:0] i_seed,
    // result item
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_read_kind,
    output logic [12:0] o_moves
);

    fsg_pkg::t_cmd cmd;
    fsg_pkg::t_sts sts;

    // sequencing only; no payload passes through it
    fsg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // grids, LFSR, scan position, move logic and result registers
    fsg_dp #(
        .GRID_W (GRID_W),
        .GRID_H (GRID_H)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_op        (i_op),
        .i_col       (i_col),
        .i_row       (i_row),
        .i_cell_kind (i_cell_kind),
        .i_seed      (i_seed),
        .o_read_kind (o_read_kind),
        .o_moves     (o_moves)
    );

endmodule
